// File: hdl/srvwf_pkg.sv
// shared types, constants and command codes for the servo register write framer
// no dependencies
package srvwf_pkg;

	localparam int SRVWF_QUEUE_DEPTH = 2;

	localparam logic [7:0] HDR_BYTE     = 8'hFF;
	localparam logic [7:0] WRITE_INSTR  = 8'h03;
	localparam logic [7:0] ADDR_TORQUE  = 8'h18;
	localparam logic [7:0] ADDR_LED     = 8'h19;
	localparam logic [7:0] ADDR_SPEED   = 8'h20;
	localparam logic [7:0] ADDR_GOAL    = 8'h1E;
	localparam logic [7:0] ADDR_TLIMIT  = 8'h22;
	localparam logic [7:0] TORQUE_ON    = 8'h01;
	localparam logic [7:0] LEN_ONE_DATA = 8'h04;
	localparam logic [7:0] LEN_TWO_DATA = 8'h05;

	typedef enum logic [2:0] {
		CMD_TORQUE_EN = 3'd0,
		CMD_LED       = 3'd1,
		CMD_SPEED     = 3'd2,
		CMD_GOAL      = 3'd3,
		CMD_TLIMIT    = 3'd4
	} cmd_e_t;

	typedef enum logic [3:0] {
		POS_HDR0,
		POS_HDR1,
		POS_ID,
		POS_LEN,
		POS_INSTR,
		POS_ADDR,
		POS_DLO,
		POS_DHI,
		POS_SUM
	} pos_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  servo_id;
		logic [15:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
	} pkt_word_t;

	// classified packet, everything the back end needs
	typedef struct packed {
		logic [7:0] servo_id;
		logic [7:0] address;
		logic [7:0] data_lo;
		logic [7:0] data_hi;
		logic       two_data;
	} frame_t;

	typedef struct packed {
		logic   push;
		frame_t frame;
	} frame_push_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} frame_pop_t;

endpackage

// File: hdl/servo_register_write_framer.sv
// servo register write framer: turns one command into a framed serial write packet
// a command passes through the queue and the back end's output register before its first header byte is shown
// throughput: one packet byte per cycle while pkt_ready is high and a frame is queued; a packet is 8 bytes
//   for one data byte, 9 for two, set by the byte sequencer in the back end
// commands keep being accepted while the queue between front and back has room
// reset: arst_n clears the queue, the sequencer and the output valid flag
module servo_register_write_framer import srvwf_pkg::*; #(
	parameter int QUEUE_DEPTH = SRVWF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	// command channel
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd_word,
	// packet byte channel
	output logic      pkt_valid,
	input  logic      pkt_ready,
	output pkt_word_t pkt_word
);

	frame_push_t push;
	frame_pop_t  head;
	logic        queue_full;
	logic        pop;

	// front: classify commands, unknown codes are taken and dropped
	srvwf_front u_front (
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_word   (cmd_word),
		.queue_full (queue_full),
		.push       (push)
	);

	// queue of classified frames, lets front and back stall on their own
	srvwf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.pop    (pop),
		.head   (head)
	);

	// back: walk the packet one byte per word, checksum on the last
	srvwf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt_word  (pkt_word)
	);

endmodule

// File: hdl/srvwf_front.sv
// front end: accepts commands, drops unknown codes, builds the frame descriptor
// depends on srvwf_pkg
module srvwf_front import srvwf_pkg::*; (
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_word_t   cmd_word,
	input  logic        queue_full,
	output frame_push_t push
);

	logic known;

	assign cmd_ready = !queue_full;

	always_comb begin
		known                 = 1'b1;
		push.frame.servo_id   = cmd_word.servo_id;
		push.frame.data_lo    = cmd_word.value[7:0];
		push.frame.data_hi    = cmd_word.value[15:8];
		push.frame.two_data   = 1'b1;
		push.frame.address    = ADDR_TLIMIT;
		case (cmd_word.command)
			CMD_TORQUE_EN: begin
				push.frame.address  = ADDR_TORQUE;
				push.frame.data_lo  = TORQUE_ON;
				push.frame.two_data = 1'b0;
			end
			CMD_LED: begin
				push.frame.address  = ADDR_LED;
				push.frame.two_data = 1'b0;
			end
			CMD_SPEED:  push.frame.address = ADDR_SPEED;
			CMD_GOAL:   push.frame.address = ADDR_GOAL;
			CMD_TLIMIT: push.frame.address = ADDR_TLIMIT;
			default:    known = 1'b0;
		endcase
		push.push = cmd_valid && cmd_ready && known;
	end

endmodule

// File: hdl/srvwf_queue.sv
// small descriptor queue between front and back end
// depends on srvwf_pkg
module srvwf_queue import srvwf_pkg::*; #(
	parameter int DEPTH = SRVWF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_push_t push,
	output logic        full,
	input  logic        pop,
	output frame_pop_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frame_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.frame = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/srvwf_back.sv
// back end: byte sequencer with running checksum and output register
// depends on srvwf_pkg
module srvwf_back import srvwf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  frame_pop_t head,
	output logic       pop,
	output logic       pkt_valid,
	input  logic       pkt_ready,
	output pkt_word_t  pkt_word
);

	pos_t      pos_q, pos_d;
	frame_t    held_q;
	logic [7:0] sum_q, sum_d;
	logic      out_valid_q;
	pkt_word_t out_q;
	logic      advance;
	logic      emit;
	pkt_word_t byte_d;

	assign advance   = !out_valid_q || pkt_ready;
	assign pkt_valid = out_valid_q;
	assign pkt_word  = out_q;

	always_comb begin
		pos_d          = pos_q;
		sum_d          = sum_q;
		pop            = 1'b0;
		emit           = 1'b0;
		byte_d.packet_byte = HDR_BYTE;
		byte_d.last_byte   = 1'b0;
		case (pos_q)
			POS_HDR0: begin
				if (advance && head.valid) begin
					pop   = 1'b1;
					emit  = 1'b1;
					pos_d = POS_HDR1;
				end
			end
			POS_HDR1: begin
				emit  = advance;
				pos_d = advance ? POS_ID : pos_q;
			end
			POS_ID: begin
				byte_d.packet_byte = held_q.servo_id;
				emit  = advance;
				sum_d = advance ? held_q.servo_id : sum_q;
				pos_d = advance ? POS_LEN : pos_q;
			end
			POS_LEN: begin
				byte_d.packet_byte = held_q.two_data ? LEN_TWO_DATA : LEN_ONE_DATA;
				emit  = advance;
				pos_d = advance ? POS_INSTR : pos_q;
			end
			POS_INSTR: begin
				byte_d.packet_byte = WRITE_INSTR;
				emit  = advance;
				pos_d = advance ? POS_ADDR : pos_q;
			end
			POS_ADDR: begin
				byte_d.packet_byte = held_q.address;
				emit  = advance;
				pos_d = advance ? POS_DLO : pos_q;
			end
			POS_DLO: begin
				byte_d.packet_byte = held_q.data_lo;
				emit  = advance;
				if (advance) begin
					pos_d = held_q.two_data ? POS_DHI : POS_SUM;
				end
			end
			POS_DHI: begin
				byte_d.packet_byte = held_q.data_hi;
				emit  = advance;
				pos_d = advance ? POS_SUM : pos_q;
			end
			POS_SUM: begin
				byte_d.packet_byte = ~sum_q;
				byte_d.last_byte   = 1'b1;
				emit  = advance;
				pos_d = advance ? POS_HDR0 : pos_q;
			end
			default: pos_d = POS_HDR0;
		endcase
		// body bytes after the id add into the checksum
		if (advance && (pos_q == POS_LEN || pos_q == POS_INSTR || pos_q == POS_ADDR
				|| pos_q == POS_DLO || pos_q == POS_DHI)) begin
			sum_d = sum_q + byte_d.packet_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HDR0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			sum_q <= sum_d;
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			held_q <= head.frame;
		end
		if (advance && emit) begin
			out_q <= byte_d;
		end
	end

endmodule
